// File: hdl/psp_pkg.sv
`default_nettype none

package psp_pkg;

  // field widths
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int LEN_W    = 50;
  localparam int DOT_W    = PROD_W + 1;
  localparam int MAG_W    = 50;
  localparam int PARAM_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = PARAM_W - 1;
  localparam int SAT_SH   = QUO_W - FRAC_W;
  localparam int TPROD_W  = DIFF_W + PARAM_W;
  localparam int DIST_W   = 50;
  localparam int TOL_W    = 16;
  localparam int LIMIT_W  = 32;
  localparam int CFG_W    = 32;

  // one divider stage per quotient bit
  localparam int DIV_STAGES = QUO_W;

  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  localparam logic signed [PARAM_W-1:0] PARAM_ONE = 32'sd65536;
  localparam logic signed [PARAM_W-1:0] PARAM_MAX = 32'sh7FFFFFFF;
  localparam logic signed [PARAM_W-1:0] PARAM_MIN = 32'sh80000000;
  localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TOLERANCE = 1'b0,
    CFG_ZERO_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      clamp_enable;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [PARAM_W-1:0] line_param;
    logic [DIST_W-1:0]         dist_sq;
    logic                      on_segment;
  } out_rsp_t;

  // per-request data that rides along the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
    logic               clamp;
    logic               degen;
    logic               neg;
    logic               sat;
  } side_t;

  // divider stage payload
  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [QUO_W-1:0] feed;
    logic [QUO_W-1:0] quo;
    logic [LEN_W-1:0] len;
    side_t            side;
  } div_t;

endpackage

`default_nettype wire

// File: hdl/psp_front.sv
`default_nettype none

module psp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic                            in_valid,
  input  psp_pkg::in_req_t                in_data,
  input  logic [psp_pkg::LIMIT_W-1:0]     zero_length_limit,
  output logic                            out_valid,
  output psp_pkg::div_t                   out_data
);

  logic [4:0] vld_r;

  psp_pkg::side_t s1_side_r, s1_side_nxt;
  logic [psp_pkg::DIFF_W-1:0] s1_wx_r, s1_wx_nxt, s1_wy_r, s1_wy_nxt;

  psp_pkg::side_t s2_side_r;
  logic signed [psp_pkg::PROD_W-1:0] s2_xx_r, s2_xx_nxt, s2_yy_r, s2_yy_nxt;
  logic signed [psp_pkg::PROD_W-1:0] s2_xd_r, s2_xd_nxt, s2_yd_r, s2_yd_nxt;

  psp_pkg::side_t s3_side_r;
  logic [psp_pkg::LEN_W-1:0] s3_len_r, s3_len_nxt;
  logic [psp_pkg::DOT_W-1:0] s3_dot_r, s3_dot_nxt;

  psp_pkg::side_t s4_side_r, s4_side_nxt;
  logic [psp_pkg::LEN_W-1:0] s4_len_r;
  logic [psp_pkg::MAG_W-1:0] s4_mag_r, s4_mag_nxt;
  logic [psp_pkg::DOT_W-1:0] s4_dot_neg;

  psp_pkg::div_t s5_r, s5_nxt;

  // stage 1: coordinate differences
  always_comb begin
    s1_side_nxt.px    = in_data.point_x;
    s1_side_nxt.py    = in_data.point_y;
    s1_side_nxt.sx    = in_data.start_x;
    s1_side_nxt.sy    = in_data.start_y;
    s1_side_nxt.dx    = {in_data.end_x[23], in_data.end_x} -
                        {in_data.start_x[23], in_data.start_x};
    s1_side_nxt.dy    = {in_data.end_y[23], in_data.end_y} -
                        {in_data.start_y[23], in_data.start_y};
    s1_side_nxt.clamp = in_data.clamp_enable;
    s1_side_nxt.degen = 1'b0;
    s1_side_nxt.neg   = 1'b0;
    s1_side_nxt.sat   = 1'b0;
    s1_wx_nxt = {in_data.point_x[23], in_data.point_x} -
                {in_data.start_x[23], in_data.start_x};
    s1_wy_nxt = {in_data.point_y[23], in_data.point_y} -
                {in_data.start_y[23], in_data.start_y};
  end

  // stage 2: the four products
  always_comb begin
    s2_xx_nxt = $signed(s1_side_r.dx) * $signed(s1_side_r.dx);
    s2_yy_nxt = $signed(s1_side_r.dy) * $signed(s1_side_r.dy);
    s2_xd_nxt = $signed(s1_wx_r) * $signed(s1_side_r.dx);
    s2_yd_nxt = $signed(s1_wy_r) * $signed(s1_side_r.dy);
  end

  // stage 3: squared length and dot product
  always_comb begin
    s3_len_nxt = $unsigned(s2_xx_r) + $unsigned(s2_yy_r);
    s3_dot_nxt = {s2_xd_r[psp_pkg::PROD_W-1], s2_xd_r} +
                 {s2_yd_r[psp_pkg::PROD_W-1], s2_yd_r};
  end

  // stage 4: degenerate test, sign and magnitude of the dot product
  always_comb begin
    s4_side_nxt       = s3_side_r;
    s4_side_nxt.degen = s3_len_r <= {{(psp_pkg::LEN_W - psp_pkg::LIMIT_W){1'b0}},
                                     zero_length_limit};
    s4_side_nxt.neg   = s3_dot_r[psp_pkg::DOT_W-1];
    s4_dot_neg        = -s3_dot_r;
    s4_mag_nxt        = s3_dot_r[psp_pkg::DOT_W-1] ? s4_dot_neg[psp_pkg::MAG_W-1:0]
                                                   : s3_dot_r[psp_pkg::MAG_W-1:0];
  end

  // stage 5: overflow check and divider setup
  always_comb begin
    s5_nxt.side     = s4_side_r;
    s5_nxt.side.sat = {{psp_pkg::SAT_SH{1'b0}}, s4_mag_r} >=
                      {s4_len_r, {psp_pkg::SAT_SH{1'b0}}};
    s5_nxt.rem      = {{psp_pkg::SAT_SH{1'b0}}, s4_mag_r[psp_pkg::MAG_W-1:psp_pkg::SAT_SH]};
    s5_nxt.feed     = {s4_mag_r[psp_pkg::SAT_SH-1:0], {psp_pkg::FRAC_W{1'b0}}};
    s5_nxt.quo      = '0;
    s5_nxt.len      = s4_len_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_side_r <= s1_side_nxt;
      s1_wx_r   <= s1_wx_nxt;
      s1_wy_r   <= s1_wy_nxt;
      s2_side_r <= s1_side_r;
      s2_xx_r   <= s2_xx_nxt;
      s2_yy_r   <= s2_yy_nxt;
      s2_xd_r   <= s2_xd_nxt;
      s2_yd_r   <= s2_yd_nxt;
      s3_side_r <= s2_side_r;
      s3_len_r  <= s3_len_nxt;
      s3_dot_r  <= s3_dot_nxt;
      s4_side_r <= s4_side_nxt;
      s4_len_r  <= s3_len_r;
      s4_mag_r  <= s4_mag_nxt;
      s5_r      <= s5_nxt;
    end
  end

  assign out_valid = vld_r[4];
  assign out_data  = s5_r;

endmodule

`default_nettype wire

// File: hdl/psp_div_stage.sv
`default_nettype none

module psp_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  psp_pkg::div_t in_data,
  output logic          out_valid,
  output psp_pkg::div_t out_data
);

  logic          valid_r;
  psp_pkg::div_t data_r, data_nxt;
  logic [psp_pkg::LEN_W:0] trial;
  logic [psp_pkg::LEN_W:0] diff;
  logic                    take;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial         = {in_data.rem, in_data.feed[psp_pkg::QUO_W-1]};
    diff          = trial - {1'b0, in_data.len};
    take          = trial >= {1'b0, in_data.len};
    data_nxt      = in_data;
    data_nxt.rem  = take ? diff[psp_pkg::LEN_W-1:0] : trial[psp_pkg::LEN_W-1:0];
    data_nxt.feed = {in_data.feed[psp_pkg::QUO_W-2:0], 1'b0};
    data_nxt.quo  = {in_data.quo[psp_pkg::QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// File: hdl/psp_back.sv
`default_nettype none

module psp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_valid,
  input  psp_pkg::div_t               in_data,
  input  logic [psp_pkg::TOL_W-1:0]   on_segment_tolerance,
  output logic                        out_valid,
  output psp_pkg::out_rsp_t           out_data
);

  // round a Q.16 product to Q.0, add the base and saturate
  function automatic logic [psp_pkg::COORD_W-1:0] interp_round(
    input logic signed [psp_pkg::TPROD_W-1:0] prod,
    input logic [psp_pkg::COORD_W-1:0]        base
  );
    logic signed [psp_pkg::TPROD_W-1:0] rnd;
    logic signed [psp_pkg::TPROD_W-1:0] sh;
    logic [41:0]                        sum;
    logic [psp_pkg::COORD_W-1:0]        res;
    rnd = prod + psp_pkg::TPROD_W'(psp_pkg::ROUND_HALF);
    sh  = rnd >>> psp_pkg::FRAC_W;
    sum = {sh[40], sh[40:0]} + {{18{base[23]}}, base};
    if ((sum[41:23] != '0) && (sum[41:23] != '1)) begin
      res = sum[41] ? psp_pkg::COORD_MIN : psp_pkg::COORD_MAX;
    end else begin
      res = sum[23:0];
    end
    return res;
  endfunction

  logic [6:0] vld_r;

  psp_pkg::side_t b1_side_r;
  logic [psp_pkg::PARAM_W-1:0] b1_raw_r, b1_raw_nxt;
  logic [psp_pkg::PARAM_W-1:0] quo_ext;

  psp_pkg::side_t b2_side_r;
  logic signed [psp_pkg::PARAM_W-1:0] b2_t_r, b2_t_nxt;
  logic b2_onseg_r, b2_onseg_nxt;
  logic signed [33:0] raw_ext, tol_ext, lo_bound, hi_bound;

  logic [psp_pkg::COORD_W-1:0] b3_px_r, b3_py_r, b3_sx_r, b3_sy_r;
  logic signed [psp_pkg::PARAM_W-1:0] b3_t_r;
  logic b3_onseg_r;
  logic signed [psp_pkg::TPROD_W-1:0] b3_prodx_r, b3_prodx_nxt, b3_prody_r, b3_prody_nxt;

  logic [psp_pkg::COORD_W-1:0] b4_px_r, b4_py_r, b4_qx_r, b4_qy_r;
  logic signed [psp_pkg::PARAM_W-1:0] b4_t_r;
  logic b4_onseg_r;

  logic [psp_pkg::COORD_W-1:0] b5_qx_r, b5_qy_r;
  logic signed [psp_pkg::PARAM_W-1:0] b5_t_r;
  logic b5_onseg_r;
  logic [psp_pkg::DIFF_W-1:0] b5_rx_r, b5_rx_nxt, b5_ry_r, b5_ry_nxt;

  logic [psp_pkg::COORD_W-1:0] b6_qx_r, b6_qy_r;
  logic signed [psp_pkg::PARAM_W-1:0] b6_t_r;
  logic b6_onseg_r;
  logic signed [psp_pkg::PROD_W-1:0] b6_sqx_r, b6_sqx_nxt, b6_sqy_r, b6_sqy_nxt;

  psp_pkg::out_rsp_t b7_r, b7_nxt;

  // stage 1: signed parameter with saturation
  always_comb begin
    quo_ext = {1'b0, in_data.quo};
    if (in_data.side.sat) begin
      b1_raw_nxt = in_data.side.neg ? psp_pkg::PARAM_MIN : psp_pkg::PARAM_MAX;
    end else begin
      b1_raw_nxt = in_data.side.neg ? -quo_ext : quo_ext;
    end
  end

  // stage 2: tolerance window, clamp, degenerate override
  always_comb begin
    raw_ext  = $signed({{2{b1_raw_r[psp_pkg::PARAM_W-1]}}, b1_raw_r});
    tol_ext  = $signed({{(34 - psp_pkg::TOL_W){1'b0}}, on_segment_tolerance});
    lo_bound = -tol_ext;
    hi_bound = tol_ext + 34'sd65536;
    b2_onseg_nxt = b1_side_r.clamp || ((raw_ext >= lo_bound) && (raw_ext <= hi_bound));
    b2_t_nxt     = $signed(b1_raw_r);
    if (b1_side_r.clamp) begin
      if (b1_raw_r[psp_pkg::PARAM_W-1]) begin
        b2_t_nxt = '0;
      end else if ($signed(b1_raw_r) > psp_pkg::PARAM_ONE) begin
        b2_t_nxt = psp_pkg::PARAM_ONE;
      end
    end
    if (b1_side_r.degen) begin
      b2_t_nxt     = '0;
      b2_onseg_nxt = 1'b1;
    end
  end

  // stage 3: direction times parameter
  always_comb begin
    b3_prodx_nxt = $signed(b2_side_r.dx) * b2_t_r;
    b3_prody_nxt = $signed(b2_side_r.dy) * b2_t_r;
  end

  // stage 5: residual vector
  always_comb begin
    b5_rx_nxt = {b4_px_r[23], b4_px_r} - {b4_qx_r[23], b4_qx_r};
    b5_ry_nxt = {b4_py_r[23], b4_py_r} - {b4_qy_r[23], b4_qy_r};
  end

  // stage 6: squares
  always_comb begin
    b6_sqx_nxt = $signed(b5_rx_r) * $signed(b5_rx_r);
    b6_sqy_nxt = $signed(b5_ry_r) * $signed(b5_ry_r);
  end

  // stage 7: result assembly
  always_comb begin
    b7_nxt.proj_x     = b6_qx_r;
    b7_nxt.proj_y     = b6_qy_r;
    b7_nxt.line_param = b6_t_r;
    b7_nxt.dist_sq    = $unsigned(b6_sqx_r) + $unsigned(b6_sqy_r);
    b7_nxt.on_segment = b6_onseg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b1_side_r  <= in_data.side;
      b1_raw_r   <= b1_raw_nxt;
      b2_side_r  <= b1_side_r;
      b2_t_r     <= b2_t_nxt;
      b2_onseg_r <= b2_onseg_nxt;
      b3_px_r    <= b2_side_r.px;
      b3_py_r    <= b2_side_r.py;
      b3_sx_r    <= b2_side_r.sx;
      b3_sy_r    <= b2_side_r.sy;
      b3_t_r     <= b2_t_r;
      b3_onseg_r <= b2_onseg_r;
      b3_prodx_r <= b3_prodx_nxt;
      b3_prody_r <= b3_prody_nxt;
      b4_px_r    <= b3_px_r;
      b4_py_r    <= b3_py_r;
      b4_qx_r    <= interp_round(b3_prodx_r, b3_sx_r);
      b4_qy_r    <= interp_round(b3_prody_r, b3_sy_r);
      b4_t_r     <= b3_t_r;
      b4_onseg_r <= b3_onseg_r;
      b5_qx_r    <= b4_qx_r;
      b5_qy_r    <= b4_qy_r;
      b5_t_r     <= b4_t_r;
      b5_onseg_r <= b4_onseg_r;
      b5_rx_r    <= b5_rx_nxt;
      b5_ry_r    <= b5_ry_nxt;
      b6_qx_r    <= b5_qx_r;
      b6_qy_r    <= b5_qy_r;
      b6_t_r     <= b5_t_r;
      b6_onseg_r <= b5_onseg_r;
      b6_sqx_r   <= b6_sqx_nxt;
      b6_sqy_r   <= b6_sqy_nxt;
      b7_r       <= b7_nxt;
    end
  end

  assign out_valid = vld_r[6];
  assign out_data  = b7_r;

endmodule

`default_nettype wire

// File: hdl/point_segment_projection_unit.sv
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall  | in_data   (psp_pkg::in_req_t)
// out_     | output    | out_valid / out_stall| out_data  (psp_pkg::out_rsp_t)
// cfg_     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One request per cycle while in_stall is low. The divider has 31 stages,
// one quotient bit per stage, and sits between a 5-stage front end and a
// 7-stage back end.
// rst_n is synchronous: clears all valid bits, both config registers go to 1.
// A one-entry skid register sits at the output; in_stall is that register's
// full flag, so the whole pipeline holds while it is occupied.
`default_nettype none

module point_segment_projection_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  psp_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output psp_pkg::out_rsp_t         out_data,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [psp_pkg::CFG_W-1:0] cfg_wdata
);

  logic [psp_pkg::TOL_W-1:0]   tol_r;
  logic [psp_pkg::LIMIT_W-1:0] limit_r;

  logic ce;
  logic accept;

  logic          div_valid [0:psp_pkg::DIV_STAGES];
  psp_pkg::div_t div_data  [0:psp_pkg::DIV_STAGES];

  logic              pipe_valid;
  psp_pkg::out_rsp_t pipe_data;

  logic              skid_valid_r, skid_valid_nxt;
  psp_pkg::out_rsp_t skid_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= psp_pkg::TOL_W'(1);
      limit_r <= psp_pkg::LIMIT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        psp_pkg::CFG_TOLERANCE:  tol_r   <= cfg_wdata[psp_pkg::TOL_W-1:0];
        psp_pkg::CFG_ZERO_LIMIT: limit_r <= cfg_wdata[psp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the skid register is empty
  assign ce       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  psp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .ce                (ce),
    .in_valid          (accept),
    .in_data           (in_data),
    .zero_length_limit (limit_r),
    .out_valid         (div_valid[0]),
    .out_data          (div_data[0])
  );

  // divider chain
  for (genvar g = 0; g < psp_pkg::DIV_STAGES; g++) begin : g_div
    psp_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ce        (ce),
      .in_valid  (div_valid[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  psp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ce                   (ce),
    .in_valid             (div_valid[psp_pkg::DIV_STAGES]),
    .in_data              (div_data[psp_pkg::DIV_STAGES]),
    .on_segment_tolerance (tol_r),
    .out_valid            (pipe_valid),
    .out_data             (pipe_data)
  );

  // skid register catches the last stage when the consumer stalls
  always_comb begin
    if (skid_valid_r) begin
      skid_valid_nxt = out_stall;
    end else begin
      skid_valid_nxt = pipe_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_data_r <= pipe_data;
    end
  end

  // output select
  assign out_valid = skid_valid_r || pipe_valid;
  assign out_data  = skid_valid_r ? skid_data_r : pipe_data;

`ifndef NO_ASSERTIONS
  // skid only fills or stays full under a stalled output
  a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> $past(out_stall))
    else $error("skid register full without an output stall");

  // skid contents never change while it stays occupied
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && $past(skid_valid_r)) |-> $stable(skid_data_r))
    else $error("skid register data changed while held");

  // off-segment results always carry a parameter outside 0..1
  a_off_segment_param: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.on_segment) |->
      (out_data.line_param[psp_pkg::PARAM_W-1] ||
       ($signed(out_data.line_param) > psp_pkg::PARAM_ONE)))
    else $error("on_segment clear with parameter inside 0..1");
`endif

endmodule

`default_nettype wire
